/* hdl/cwcc_pkg.sv */
// ----------------------------------------------------------------------------
// Cyclic window cover count package
// Shared constants, controller state type, command and status structs,
// and the Hamming distance helper.
// ----------------------------------------------------------------------------
package cwcc_pkg;

    localparam int WORD_BITS    = 12;
    localparam int COVER_RADIUS = 3;
    localparam int MAX_SEQ_LEN  = 35;

    localparam int CFG_W       = 6;
    localparam int S_TDATA_W   = ((MAX_SEQ_LEN + 7) / 8) * 8;
    localparam int CNT_W       = WORD_BITS + 1;
    localparam int M_TDATA_W   = ((CNT_W + 7) / 8) * 8;
    localparam int LEN_W       = $clog2(MAX_SEQ_LEN + 1);
    localparam int PTR_W       = $clog2(MAX_SEQ_LEN);
    localparam int EXT_LEN     = MAX_SEQ_LEN + WORD_BITS - 1;
    localparam int FILL_CYCLES = EXT_LEN;
    localparam int FILL_W      = $clog2(FILL_CYCLES);
    localparam int DIST_W      = $clog2(WORD_BITS + 1);
    localparam int NUM_WORDS   = 1 << WORD_BITS;

    localparam logic [CFG_W-1:0] SEQ_LENGTH_RESET = CFG_W'(24);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic fill;
        logic scan;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic scan_last;
        logic out_free;
    } status_t;

    function automatic logic [DIST_W-1:0] hamming(input logic [WORD_BITS-1:0] a,
                                                  input logic [WORD_BITS-1:0] b);
        logic [WORD_BITS-1:0] diff;
        logic [DIST_W-1:0]    sum;
        diff = a ^ b;
        sum  = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            sum = sum + DIST_W'(diff[i]);
        end
        return sum;
    endfunction

endpackage

/* hdl/cwcc_ctrl.sv */
// ----------------------------------------------------------------------------
// Cyclic window cover count controller
// Sequences capture, window buffer fill, word scan and result hand-off.
// ----------------------------------------------------------------------------
module cwcc_ctrl
    import cwcc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (status.fill_last) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.fill    = 1'b0;
        cmd.scan    = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/cwcc_datapath.sv */
// ----------------------------------------------------------------------------
// Cyclic window cover count datapath
// Holds the length register, builds the unrolled cyclic sequence, checks one
// word per cycle against all windows and keeps the result register.
// ----------------------------------------------------------------------------
module cwcc_datapath
    import cwcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [MAX_SEQ_LEN-1:0] seq_bits,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [CNT_W-1:0]     uncovered_words
);

    logic [CFG_W-1:0]       seq_length_reg;
    logic [MAX_SEQ_LEN-1:0] bits_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_sat;
    logic [PTR_W-1:0]       ptr_reg;
    logic [LEN_W:0]         ptr_inc;
    logic [FILL_W-1:0]      fill_cnt_reg;
    logic [EXT_LEN-1:0]     ext_reg;
    logic [WORD_BITS-1:0]   word_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   out_valid_reg;
    logic [CNT_W-1:0]       out_data_reg;
    logic [MAX_SEQ_LEN-1:0] hit;
    logic                   uncovered;

    assign len_sat = (seq_length_reg > CFG_W'(MAX_SEQ_LEN)) ? LEN_W'(MAX_SEQ_LEN)
                                                            : LEN_W'(seq_length_reg);
    assign ptr_inc = (LEN_W + 1)'(ptr_reg) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg <= SEQ_LENGTH_RESET;
        end else if (cfg_valid) begin
            seq_length_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            ptr_reg      <= '0;
            fill_cnt_reg <= '0;
            word_reg     <= '0;
            count_reg    <= '0;
        end else if (cmd.capture) begin
            len_reg      <= len_sat;
            ptr_reg      <= '0;
            fill_cnt_reg <= '0;
            word_reg     <= '0;
            count_reg    <= '0;
        end else if (cmd.fill) begin
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
            if (ptr_inc >= (LEN_W + 1)'(len_reg)) begin
                ptr_reg <= '0;
            end else begin
                ptr_reg <= ptr_inc[PTR_W-1:0];
            end
        end else if (cmd.scan) begin
            word_reg  <= word_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(uncovered);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            bits_reg <= seq_bits;
        end
        if (cmd.fill) begin
            ext_reg <= {bits_reg[ptr_reg], ext_reg[EXT_LEN-1:1]};
        end
    end

    always_comb begin
        logic [WORD_BITS-1:0] win;
        for (int s = 0; s < MAX_SEQ_LEN; s++) begin
            for (int k = 0; k < WORD_BITS; k++) begin
                win[WORD_BITS-1-k] = ext_reg[s+k];
            end
            hit[s] = (LEN_W'(s) < len_reg)
                     && (hamming(word_reg, win) <= DIST_W'(COVER_RADIUS));
        end
    end

    assign uncovered = ~|hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= count_reg;
        end
    end

    assign status.fill_last = (fill_cnt_reg == FILL_W'(FILL_CYCLES - 1));
    assign status.scan_last = (word_reg == {WORD_BITS{1'b1}});
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid        = out_valid_reg;
    assign uncovered_words = out_data_reg;

`ifndef SYNTH
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("Result loaded while the previous one is still held.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(NUM_WORDS))
        else $error("Uncovered word count beyond the word space.");

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) || ((LEN_W + 1)'(ptr_reg) < (LEN_W + 1)'(len_reg)))
        else $error("Sequence pointer beyond the captured length.");

    a_len_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_SEQ_LEN))
        else $error("Captured length not saturated.");
`endif

endmodule

/* hdl/cyclic_window_cover_count.sv */
// ----------------------------------------------------------------------------
// Cyclic window cover count
// Counts the words at Hamming distance above the cover radius from every
// cyclic window of a configured binary sequence.
// ----------------------------------------------------------------------------
// The sequence arrives on the s_ stream channel, one transfer per sequence,
// and the count leaves on the m_ stream channel, one transfer per sequence.
// The cfg_ channel writes the sequence length; it is always ready and may be
// written only while the block is idle. Lengths above the maximum saturate.
// After a transfer is accepted, the block unrolls the cyclic sequence into
// a window buffer through a shift line, then checks one word per cycle
// against all windows at once. The count is then loaded into the output
// register once that register is free; a new sequence can be accepted the
// cycle after that. The block takes no new sequence until the count of the
// last one is loaded into the output register.
// If the receiver stalls, the result waits in the output register while the
// next sequence is taken and processed; only that sequence's result waits
// for the register to free up. Reset empties the output register, returns
// the controller to idle and sets the length to 24.
// ----------------------------------------------------------------------------
module cyclic_window_cover_count
    import cwcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,      // seq_length
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // seq_bits, then zero padding
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // uncovered_words, then zero padding
);

    cmd_t             cmd;
    status_t          status;
    logic [CNT_W-1:0] uncovered_words;

    assign cfg_ready = 1'b1;
    assign m_tdata   = M_TDATA_W'(uncovered_words);

    cwcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cwcc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .seq_bits        (s_tdata[MAX_SEQ_LEN-1:0]),
        .cmd             (cmd),
        .status          (status),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .uncovered_words (uncovered_words)
    );

endmodule
